[src/nrmc_pkg.sv]
// Shared constants, types and a helper function for the GPRMC sentence parser.
package nrmc_pkg;

    // Character codes recognized by the parser.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_E      = 8'h45;

    // Field counter codes.
    localparam logic [3:0] FLD_HEADER     = 4'd0;
    localparam logic [3:0] FLD_TIME       = 4'd1;
    localparam logic [3:0] FLD_STATUS     = 4'd2;
    localparam logic [3:0] FLD_LAT        = 4'd3;
    localparam logic [3:0] FLD_LAT_HEMI   = 4'd4;
    localparam logic [3:0] FLD_LON        = 4'd5;
    localparam logic [3:0] FLD_LON_HEMI   = 4'd6;
    localparam logic [3:0] FLD_TAIL_FIRST = 4'd7;
    localparam logic [3:0] FLD_TAIL_LAST  = 4'd12;
    localparam logic [3:0] FLD_PAST_END   = 4'd13;
    localparam logic [3:0] FLD_IDLE       = 4'd15;

    // Header and time field limits.
    localparam logic [2:0] HEADER_LEN  = 3'd5;
    localparam logic [2:0] TIME_DIGITS = 3'd6;

    // Field widths.
    localparam int TIME_W  = 20;
    localparam int COORD_W = 32;

    // One result item as produced by the parse core.
    typedef struct packed {
        logic                 record_ready;
        logic [TIME_W-1:0]    utc_time;
        logic [COORD_W-1:0]   latitude_raw;
        logic [COORD_W-1:0]   longitude_raw;
        logic                 fix_valid;
        logic [7:0]           lat_hemisphere;
        logic [7:0]           lon_hemisphere;
    } nrmc_result_t;

    // Expected header character at a given position of "GPRMC".
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h47;
            3'd1:    ch = 8'h50;
            3'd2:    ch = 8'h52;
            3'd3:    ch = 8'h4D;
            3'd4:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[src/nrmc_parse_core.sv]
// Parser state registers and the per-byte next-state and result logic.
module nrmc_parse_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_en,
    input  logic [7:0]            byte_in,
    output nrmc_pkg::nrmc_result_t result
);

    logic [3:0]  field_reg,  field_next;
    logic [2:0]  charpos_reg, charpos_next;
    logic [2:0]  hdr_reg,    hdr_next;
    logic [31:0] acc_reg,    acc_next;
    logic [19:0] time_reg,   time_next;
    logic [31:0] lat_reg,    lat_next;
    logic [31:0] lon_reg,    lon_next;
    logic        valid_reg,  valid_next;
    logic [7:0]  lat_hemi_reg, lat_hemi_next;
    logic [7:0]  lon_hemi_reg, lon_hemi_next;
    logic        ready_flag;

    logic        is_digit;
    logic [31:0] acc_pushed;

    // Decimal shift-in of one digit, wrapping modulo 2^32.
    assign is_digit   = (byte_in >= nrmc_pkg::CHAR_ZERO) && (byte_in <= nrmc_pkg::CHAR_NINE);
    assign acc_pushed = (acc_reg << 3) + (acc_reg << 1)
                      + {24'd0, byte_in - nrmc_pkg::CHAR_ZERO};

    // Next-state logic for one received byte.
    always_comb begin
        field_next    = field_reg;
        charpos_next  = charpos_reg;
        hdr_next      = hdr_reg;
        acc_next      = acc_reg;
        time_next     = time_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        valid_next    = valid_reg;
        lat_hemi_next = lat_hemi_reg;
        lon_hemi_next = lon_hemi_reg;
        ready_flag    = 1'b0;

        if (byte_in == nrmc_pkg::CHAR_DOLLAR) begin
            field_next   = nrmc_pkg::FLD_HEADER;
            charpos_next = 3'd0;
            hdr_next     = 3'd0;
            acc_next     = 32'd0;
        end else if (field_reg == nrmc_pkg::FLD_IDLE) begin
            // Bytes between sentences are ignored.
        end else if ((byte_in == nrmc_pkg::CHAR_CR) || (byte_in == nrmc_pkg::CHAR_LF)
                     || (byte_in == nrmc_pkg::CHAR_STAR)) begin
            field_next = nrmc_pkg::FLD_IDLE;
        end else if (byte_in == nrmc_pkg::CHAR_COMMA) begin
            if (field_reg == nrmc_pkg::FLD_TIME) begin
                time_next = acc_reg[19:0];
            end else if (field_reg == nrmc_pkg::FLD_LAT) begin
                lat_next = acc_reg;
            end else if (field_reg == nrmc_pkg::FLD_LON) begin
                lon_next = acc_reg;
            end
            if (field_reg < nrmc_pkg::FLD_PAST_END) begin
                field_next = field_reg + 4'd1;
            end
            charpos_next = 3'd0;
            acc_next     = 32'd0;
        end else begin
            case (field_reg)
                nrmc_pkg::FLD_HEADER: begin
                    if (hdr_reg < nrmc_pkg::HEADER_LEN) begin
                        if (byte_in != nrmc_pkg::header_char(hdr_reg)) begin
                            field_next = nrmc_pkg::FLD_IDLE;
                        end
                        hdr_next = hdr_reg + 3'd1;
                    end
                end
                nrmc_pkg::FLD_TIME: begin
                    if ((charpos_reg < nrmc_pkg::TIME_DIGITS) && is_digit) begin
                        acc_next     = acc_pushed;
                        charpos_next = charpos_reg + 3'd1;
                    end
                end
                nrmc_pkg::FLD_STATUS: begin
                    if (charpos_reg == 3'd0) begin
                        valid_next   = (byte_in == nrmc_pkg::CHAR_A);
                        charpos_next = 3'd1;
                    end
                end
                nrmc_pkg::FLD_LAT, nrmc_pkg::FLD_LON: begin
                    if (is_digit) begin
                        acc_next = acc_pushed;
                    end
                end
                nrmc_pkg::FLD_LAT_HEMI: begin
                    if (charpos_reg == 3'd0) begin
                        lat_hemi_next = byte_in;
                        charpos_next  = 3'd1;
                    end
                end
                nrmc_pkg::FLD_LON_HEMI: begin
                    if (charpos_reg == 3'd0) begin
                        lon_hemi_next = byte_in;
                        charpos_next  = 3'd1;
                    end
                    ready_flag = 1'b1;
                end
                default: begin
                    // Fields 7 to 12 mark ready; past the last field nothing does.
                    ready_flag = (field_reg >= nrmc_pkg::FLD_TAIL_FIRST)
                              && (field_reg <= nrmc_pkg::FLD_TAIL_LAST);
                end
            endcase
        end
    end

    // State registers advance on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg    <= nrmc_pkg::FLD_IDLE;
            charpos_reg  <= 3'd0;
            hdr_reg      <= 3'd0;
            acc_reg      <= 32'd0;
            time_reg     <= 20'd0;
            lat_reg      <= 32'd0;
            lon_reg      <= 32'd0;
            valid_reg    <= 1'b0;
            lat_hemi_reg <= nrmc_pkg::CHAR_N;
            lon_hemi_reg <= nrmc_pkg::CHAR_E;
        end else if (byte_en) begin
            field_reg    <= field_next;
            charpos_reg  <= charpos_next;
            hdr_reg      <= hdr_next;
            acc_reg      <= acc_next;
            time_reg     <= time_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            valid_reg    <= valid_next;
            lat_hemi_reg <= lat_hemi_next;
            lon_hemi_reg <= lon_hemi_next;
        end
    end

    // Result reflects the state after this byte is applied.
    assign result.record_ready   = ready_flag;
    assign result.utc_time       = time_next;
    assign result.latitude_raw   = lat_next;
    assign result.longitude_raw  = lon_next;
    assign result.fix_valid      = valid_next;
    assign result.lat_hemisphere = lat_hemi_next;
    assign result.lon_hemisphere = lon_hemi_next;

    // The field counter saturates and never lands on the unused code.
    a_field_code: assert property (@(posedge aclk) disable iff (!aresetn)
        field_reg != 4'd14)
        else $error("field counter holds an unused code");

    // The time field never shifts in more than six digits.
    a_time_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (field_reg == nrmc_pkg::FLD_TIME) |-> (charpos_reg <= nrmc_pkg::TIME_DIGITS))
        else $error("time digit count exceeded");

    // A dollar sign always restarts the header match.
    a_dollar_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_en && byte_in == nrmc_pkg::CHAR_DOLLAR)
        |=> (field_reg == nrmc_pkg::FLD_HEADER && hdr_reg == 3'd0 && acc_reg == 32'd0))
        else $error("dollar did not restart the sentence");

    // The ready flag only rises inside the longitude hemisphere or trailing fields.
    a_ready_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_flag |-> (field_reg >= nrmc_pkg::FLD_LON_HEMI
                        && field_reg <= nrmc_pkg::FLD_TAIL_LAST))
        else $error("ready flagged outside the trailing fields");

endmodule

[src/nmea_rmc_sentence_parser_top.sv]
// Top level of the GPRMC sentence parser: input handshake, core and result register.
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_valid / s_ready   | s_rx_byte[7:0]
//   m_      | out       | m_valid / m_ready   | m_record_ready, m_utc_time[19:0],
//           |           |                     | m_latitude_raw[31:0], m_longitude_raw[31:0],
//           |           |                     | m_fix_valid, m_lat_hemisphere[7:0],
//           |           |                     | m_lon_hemisphere[7:0]
//
// Each byte's result is loaded into the result register at the edge of the input
// transfer and is offered on m_ from the next cycle, and a byte can be taken every
// cycle while the result register is empty or m_ready is high.
// s_ready is high whenever the result register is empty or is being drained,
// so a stall on m_ready holds back the input only while a result waits.
// Synchronous active-low reset puts the parser core in its idle state, waiting for '$',
// with hemispheres 'N' and 'E' and all numeric fields zero; the result payload is not reset.
module nmea_rmc_sentence_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_record_ready,
    output logic [19:0] m_utc_time,
    output logic [31:0] m_latitude_raw,
    output logic [31:0] m_longitude_raw,
    output logic        m_fix_valid,
    output logic [7:0]  m_lat_hemisphere,
    output logic [7:0]  m_lon_hemisphere
);

    nrmc_pkg::nrmc_result_t core_result;
    nrmc_pkg::nrmc_result_t out_reg;
    logic                   out_valid_reg;
    logic                   s_xfer;

    // Input transfer whenever the result register can take a new value.
    assign s_ready = !out_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    nrmc_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (s_xfer),
        .byte_in (s_rx_byte),
        .result  (core_result)
    );

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded on each input transfer.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_record_ready   = out_reg.record_ready;
    assign m_utc_time       = out_reg.utc_time;
    assign m_latitude_raw   = out_reg.latitude_raw;
    assign m_longitude_raw  = out_reg.longitude_raw;
    assign m_fix_valid      = out_reg.fix_valid;
    assign m_lat_hemisphere = out_reg.lat_hemisphere;
    assign m_lon_hemisphere = out_reg.lon_hemisphere;

    // Every input transfer leaves a result waiting on the next cycle.
    a_xfer_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid)
        else $error("input transfer produced no result");

    // Input is held off only while an undelivered result waits.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting result");

    // A delivered result with no new input empties the result register.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !s_valid) |=> !m_valid)
        else $error("result register did not drain");

endmodule
